[hw/rtl/b2b_pkg.sv]
package b2b_pkg;

  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        last_word;
  } in_word_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [3:0]  valid_bytes;
    logic        digest_end;
  } out_word_t;

  localparam logic [0:7][63:0] IV = {
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
    64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam logic [0:11][0:15][3:0] SIGMA = {
    {4'd0,4'd1,4'd2,4'd3,4'd4,4'd5,4'd6,4'd7,4'd8,4'd9,4'd10,4'd11,4'd12,4'd13,4'd14,4'd15},
    {4'd14,4'd10,4'd4,4'd8,4'd9,4'd15,4'd13,4'd6,4'd1,4'd12,4'd0,4'd2,4'd11,4'd7,4'd5,4'd3},
    {4'd11,4'd8,4'd12,4'd0,4'd5,4'd2,4'd15,4'd13,4'd10,4'd14,4'd3,4'd6,4'd7,4'd1,4'd9,4'd4},
    {4'd7,4'd9,4'd3,4'd1,4'd13,4'd12,4'd11,4'd14,4'd2,4'd6,4'd5,4'd10,4'd4,4'd0,4'd15,4'd8},
    {4'd9,4'd0,4'd5,4'd7,4'd2,4'd4,4'd10,4'd15,4'd14,4'd1,4'd11,4'd12,4'd6,4'd8,4'd3,4'd13},
    {4'd2,4'd12,4'd6,4'd10,4'd0,4'd11,4'd8,4'd3,4'd4,4'd13,4'd7,4'd5,4'd15,4'd14,4'd1,4'd9},
    {4'd12,4'd5,4'd1,4'd15,4'd14,4'd13,4'd4,4'd10,4'd0,4'd7,4'd6,4'd3,4'd9,4'd2,4'd8,4'd11},
    {4'd13,4'd11,4'd7,4'd14,4'd12,4'd1,4'd3,4'd9,4'd5,4'd0,4'd15,4'd4,4'd8,4'd6,4'd2,4'd10},
    {4'd6,4'd15,4'd14,4'd9,4'd11,4'd3,4'd0,4'd8,4'd12,4'd2,4'd13,4'd7,4'd1,4'd4,4'd10,4'd5},
    {4'd10,4'd2,4'd8,4'd4,4'd7,4'd6,4'd1,4'd5,4'd15,4'd11,4'd9,4'd14,4'd3,4'd12,4'd13,4'd0},
    {4'd0,4'd1,4'd2,4'd3,4'd4,4'd5,4'd6,4'd7,4'd8,4'd9,4'd10,4'd11,4'd12,4'd13,4'd14,4'd15},
    {4'd14,4'd10,4'd4,4'd8,4'd9,4'd15,4'd13,4'd6,4'd1,4'd12,4'd0,4'd2,4'd11,4'd7,4'd5,4'd3}
  };

  localparam logic [6:0] REG_DLEN = 7'd0;
  localparam logic [6:0] REG_KLEN = 7'd1;

endpackage

[hw/rtl/b2b_half_g.sv]
// One half of the G function: add, xor-rotate, add, xor-rotate.
module b2b_half_g (
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  input  logic [63:0] c_i,
  input  logic [63:0] d_i,
  input  logic [63:0] m_i,
  input  logic        second_i,
  output logic [63:0] a_o,
  output logic [63:0] b_o,
  output logic [63:0] c_o,
  output logic [63:0] d_o
);
  logic [63:0] dx, bx;

  // Rotation amounts are 32/24 on the first half and 16/63 on the second.
  always_comb begin
    a_o = a_i + b_i + m_i;
    dx  = d_i ^ a_o;
    d_o = second_i ? {dx[15:0], dx[63:16]} : {dx[31:0], dx[63:32]};
    c_o = c_i + d_o;
    bx  = b_i ^ c_o;
    b_o = second_i ? {bx[62:0], bx[63]} : {bx[23:0], bx[63:24]};
  end
endmodule

[hw/rtl/b2b_round_unit.sv]
// Shared datapath: four half-G units step all four columns or all four diagonals by one half-G.
module b2b_round_unit
  import b2b_pkg::*;
(
  input  logic [15:0][63:0] v_i,
  input  logic [15:0][63:0] m_i,
  input  logic [3:0]        round_i,
  input  logic              diag_i,
  input  logic              second_i,
  output logic [15:0][63:0] v_o
);
  logic [3:0][3:0]  ia, ib, ic, id;
  logic [3:0][63:0] ra, rb, rc, rd, mw;

  // Select column or diagonal operands and the message word for each lane.
  always_comb begin
    for (int g = 0; g < 4; g++) begin
      ia[g] = 4'(g);
      ib[g] = diag_i ? 4'(4 + ((g + 1) % 4)) : 4'(4 + g);
      ic[g] = diag_i ? 4'(8 + ((g + 2) % 4)) : 4'(8 + g);
      id[g] = diag_i ? 4'(12 + ((g + 3) % 4)) : 4'(12 + g);
      mw[g] = m_i[SIGMA[round_i][{diag_i, 2'(g), second_i}]];
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_lane
    b2b_half_g u_g (
      .a_i(v_i[ia[g]]), .b_i(v_i[ib[g]]), .c_i(v_i[ic[g]]), .d_i(v_i[id[g]]),
      .m_i(mw[g]), .second_i(second_i),
      .a_o(ra[g]), .b_o(rb[g]), .c_o(rc[g]), .d_o(rd[g])
    );
  end

  // Scatter lane results back into the vector.
  always_comb begin
    v_o = v_i;
    for (int g = 0; g < 4; g++) begin
      v_o[ia[g]] = ra[g];
      v_o[ib[g]] = rb[g];
      v_o[ic[g]] = rc[g];
      v_o[id[g]] = rd[g];
    end
  end
endmodule

[hw/rtl/blake2b_hash_engine_core.sv]
// Flow: each accepted word is held and then loaded into the message buffer; the input stalls
// meanwhile. The word that finds the buffer full first starts a compression (12 rounds of 4
// half-G steps on four G lanes) and is loaded after it. A last word starts the final compression,
// after which the digest words are offered one per cycle while the output does not stall.
// One word at a time: no new word is taken until the previous one and its compressions are done.
// Reset: asynchronous, active low; clears control state and restores the default lengths.
module blake2b_hash_engine_core
  import b2b_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_word_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_word_t  out_data_o,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_index_i,
  input  logic [6:0] cfg_data_i
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_COMP = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [6:0]  dlen_q, klen_q;
  logic [7:0][63:0]  h_q;
  logic [15:0][63:0] m_q, v_q, v_next, v_init;
  logic [4:0]  fill_q;
  logic [63:0] cnt_lo_q, cnt_hi_q;
  logic        open_q, fin_q;
  logic [5:0]  step_q;
  logic [2:0]  oidx_q;
  logic [6:0]  remain_q;
  in_word_t    pw_q;

  logic [6:0]   dl_eff, kl_eff;
  logic         acc, out_acc, comp_done, full_blk, fin_blk;
  logic [3:0]   nb;
  logic [4:0]   fill_new;
  logic [63:0]  wmask, wdata, pword;
  logic [127:0] cnt_new;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign acc         = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == ST_OUT);
  assign out_acc     = out_valid_o && !out_stall_i;
  assign comp_done   = (state_q == ST_COMP) && (step_q == 6'd47);

  // Effective lengths, parameter word and the held word with unused bytes cleared.
  always_comb begin
    dl_eff = (dlen_q == 7'd0) ? 7'd1 : ((dlen_q > 7'd64) ? 7'd64 : dlen_q);
    kl_eff = (klen_q > 7'd64) ? 7'd64 : klen_q;
    pword  = 64'h01010000 ^ {49'd0, kl_eff, 8'd0} ^ {57'd0, dl_eff};
    nb = (!pw_q.last_word || pw_q.byte_count > 4'd8) ? 4'd8 : pw_q.byte_count;
    wmask = (nb == 4'd8) ? '1 : ((64'd1 << {nb, 3'd0}) - 64'd1);
    wdata = pw_q.data_word & wmask;
    full_blk = (nb != 4'd0) && (fill_q == 5'd16);
    fin_blk  = !full_blk && pw_q.last_word;
    fill_new = fill_q + ((nb != 4'd0) ? 5'd1 : 5'd0);
    if (full_blk) begin
      cnt_new = {cnt_hi_q, cnt_lo_q} + 128'd128;
    end else begin
      cnt_new = {cnt_hi_q, cnt_lo_q} + {120'd0, fill_q, 3'd0} + {124'd0, nb};
    end
  end

  // Working vector at the start of a compression.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      v_init[i]     = h_q[i];
      v_init[i + 8] = IV[i];
    end
    v_init[12] = IV[4] ^ cnt_new[63:0];
    v_init[13] = IV[5] ^ cnt_new[127:64];
    v_init[14] = fin_blk ? ~IV[6] : IV[6];
  end

  b2b_round_unit u_round (
    .v_i(v_q), .m_i(m_q), .round_i(step_q[5:2]), .diag_i(step_q[1]),
    .second_i(step_q[0]), .v_o(v_next)
  );

  always_comb begin
    out_data_o.digest_word = h_q[oidx_q];
    out_data_o.valid_bytes = (remain_q > 7'd8) ? 4'd8 : remain_q[3:0];
    out_data_o.digest_end  = (remain_q <= 7'd8);
  end

  // Control sequencer. After a block without the final flag, the held word is loaded again.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (acc) state_d = ST_LOAD;
      ST_LOAD: state_d = (full_blk || pw_q.last_word) ? ST_COMP : ST_IDLE;
      ST_COMP: if (step_q == 6'd47) state_d = fin_q ? ST_OUT : ST_LOAD;
      ST_OUT:  if (!out_stall_i && remain_q <= 7'd8) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      dlen_q <= 7'd64;
      klen_q <= 7'd0;
      open_q <= 1'b0;
      fill_q <= '0;
      step_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i && cfg_index_i == REG_DLEN) dlen_q <= cfg_data_i;
      if (cfg_we_i && cfg_index_i == REG_KLEN) klen_q <= cfg_data_i;
      if (state_q == ST_COMP) step_q <= step_q + 6'd1;
      else step_q <= '0;
      if (acc && !open_q) open_q <= 1'b1;
      else if (out_acc && remain_q <= 7'd8) open_q <= 1'b0;
      if (acc && !open_q) fill_q <= '0;
      else if (state_q == ST_LOAD && !full_blk) fill_q <= fill_new;
      else if (comp_done && !fin_q) fill_q <= '0;
      else if (out_acc && remain_q <= 7'd8) fill_q <= '0;
    end
  end

  // Datapath: message buffer, working vector, chain value and counters.
  always_ff @(posedge clk_i) begin
    if (acc) pw_q <= in_data_i;
    if (acc && !open_q) begin
      for (int i = 0; i < 8; i++) h_q[i] <= (i == 0) ? (IV[0] ^ pword) : IV[i];
      cnt_lo_q <= '0;
      cnt_hi_q <= '0;
    end
    if (state_q == ST_LOAD) begin
      if (full_blk || pw_q.last_word) begin
        {cnt_hi_q, cnt_lo_q} <= cnt_new;
        v_q <= v_init;
        fin_q <= fin_blk;
      end
      // Store the word; on a last word clear the slots above it.
      if (!full_blk) begin
        for (int i = 0; i < 16; i++) begin
          if (nb != 4'd0 && 5'(i) == fill_q) m_q[i] <= wdata;
          else if (pw_q.last_word && 5'(i) >= fill_new) m_q[i] <= '0;
        end
      end
    end
    if (state_q == ST_COMP) begin
      v_q <= v_next;
      if (step_q == 6'd47) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] ^ v_next[i] ^ v_next[i + 8];
        remain_q <= dl_eff;
        oidx_q <= '0;
      end
    end
    if (out_acc) begin
      remain_q <= remain_q - 7'd8;
      oidx_q <= oidx_q + 3'd1;
    end
  end
endmodule

[hw/rtl/b2b_checker.sv]
// Port-level checks for the hash engine.
module b2b_checker
  import b2b_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_data_o
);
  // No word is taken while a digest is being delivered.
  a_no_in_during_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input open during output");

  // A stalled digest word holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o)) else $error("output changed");

  // A stalled digest word stays offered.
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("output withdrawn");

  // Valid byte count stays in range.
  a_vb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.valid_bytes != 4'd0 && out_data_o.valid_bytes <= 4'd8))
    else $error("bad valid_bytes");
endmodule

bind blake2b_hash_engine_core b2b_checker u_b2b_checker (.*);

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

// Predicts BLAKE2b digests for the words sent in and holds the digest words still to come.
class blake2b_scoreboard;
  logic [6:0]   dlen_reg;
  logic [6:0]   klen_reg;
  logic [63:0]  chain[8];
  logic [63:0]  msg_blk[16];
  logic [63:0]  wv[16];
  int unsigned  fill;
  logic [127:0] byte_total;
  bit           open;
  b2b_pkg::out_word_t digest_q[$];
  int unsigned  errors;

  function new();
    dlen_reg = 7'd64;
    klen_reg = 7'd0;
    fill = 0;
    byte_total = '0;
    open = 0;
    errors = 0;
  endfunction

  function void set_reg(logic [6:0] idx, logic [6:0] val);
    if (idx == b2b_pkg::REG_DLEN) begin
      dlen_reg = val;
    end else if (idx == b2b_pkg::REG_KLEN) begin
      klen_reg = val;
    end
  endfunction

  function int unsigned dlen_eff();
    if (dlen_reg == 0) return 1;
    if (dlen_reg > 64) return 64;
    return dlen_reg;
  endfunction

  function logic [63:0] rotr(logic [63:0] x, int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function void mix(int r, int g, int a, int b, int c, int d);
    wv[a] = wv[a] + wv[b] + msg_blk[b2b_pkg::SIGMA[r][2*g]];
    wv[d] = rotr(wv[d] ^ wv[a], 32);
    wv[c] = wv[c] + wv[d];
    wv[b] = rotr(wv[b] ^ wv[c], 24);
    wv[a] = wv[a] + wv[b] + msg_blk[b2b_pkg::SIGMA[r][2*g+1]];
    wv[d] = rotr(wv[d] ^ wv[a], 16);
    wv[c] = wv[c] + wv[d];
    wv[b] = rotr(wv[b] ^ wv[c], 63);
  endfunction

  function void compress(bit fin);
    for (int i = 0; i < 8; i++) begin
      wv[i] = chain[i];
      wv[i+8] = b2b_pkg::IV[i];
    end
    wv[12] ^= byte_total[63:0];
    wv[13] ^= byte_total[127:64];
    if (fin) wv[14] = ~wv[14];
    for (int r = 0; r < 12; r++) begin
      mix(r, 0, 0, 4, 8, 12);
      mix(r, 1, 1, 5, 9, 13);
      mix(r, 2, 2, 6, 10, 14);
      mix(r, 3, 3, 7, 11, 15);
      mix(r, 4, 0, 5, 10, 15);
      mix(r, 5, 1, 6, 11, 12);
      mix(r, 6, 2, 7, 8, 13);
      mix(r, 7, 3, 4, 9, 14);
    end
    for (int i = 0; i < 8; i++) chain[i] ^= wv[i] ^ wv[i+8];
  endfunction

  // Notes one accepted message word and queues the digest once the message closes.
  function void note_word(b2b_pkg::in_word_t w);
    int unsigned nb, held, remain, nwords, klen;
    logic [63:0] word;
    b2b_pkg::out_word_t o;
    if (!open) begin
      klen = (klen_reg > 64) ? 64 : klen_reg;
      for (int i = 0; i < 8; i++) chain[i] = b2b_pkg::IV[i];
      chain[0] ^= 64'h0101_0000 ^ (64'(klen) << 8) ^ 64'(dlen_eff());
      fill = 0;
      byte_total = '0;
      open = 1;
    end
    nb = w.byte_count;
    if (!w.last_word || nb > 8) nb = 8;
    word = w.data_word;
    if (nb < 8) word &= (64'd1 << (8 * nb)) - 64'd1;
    if (nb > 0) begin
      if (fill >= 16) begin
        byte_total += 128;
        compress(0);
        fill = 0;
      end
      msg_blk[fill] = word;
      fill++;
    end
    if (!w.last_word) return;
    // Final block: pad with zeros, count the bytes held and compress with the final flag.
    held = (nb > 0) ? 8 * (fill - 1) + nb : 8 * fill;
    for (int i = fill; i < 16; i++) msg_blk[i] = '0;
    byte_total += held;
    compress(1);
    remain = dlen_eff();
    nwords = (remain + 7) / 8;
    for (int i = 0; i < nwords; i++) begin
      o.digest_word = chain[i];
      o.valid_bytes = (remain > 8) ? 4'd8 : 4'(remain);
      o.digest_end = (i + 1 == nwords);
      digest_q.push_back(o);
      remain = (remain > 8) ? remain - 8 : 0;
    end
    fill = 0;
    open = 0;
  endfunction

  // Compares one digest word with the oldest one expected.
  function void check_word(b2b_pkg::out_word_t got);
    b2b_pkg::out_word_t exp;
    if (digest_q.size() == 0) begin
      $error("digest word %h with none expected", got.digest_word);
      errors++;
      return;
    end
    exp = digest_q.pop_front();
    if (got.digest_word !== exp.digest_word) begin
      $error("digest_word: expected %h, got %h", exp.digest_word, got.digest_word);
      errors++;
    end
    if (got.valid_bytes !== exp.valid_bytes) begin
      $error("valid_bytes: expected %0d, got %0d", exp.valid_bytes, got.valid_bytes);
      errors++;
    end
    if (got.digest_end !== exp.digest_end) begin
      $error("digest_end: expected %0d, got %0d", exp.digest_end, got.digest_end);
      errors++;
    end
  endfunction

  function int unsigned pending();
    return digest_q.size();
  endfunction
endclass

module tb_top;
  import b2b_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  in_word_t   in_data_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_word_t  out_data_o;
  logic       cfg_we_i = 1'b0;
  logic [6:0] cfg_index_i = '0;
  logic [6:0] cfg_data_i = '0;

  blake2b_scoreboard digests = new();
  bit          steady = 1'b0;
  int unsigned words_sent = 0;
  int unsigned cycles = 0;

  blake2b_hash_engine_core dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Digest side: check accepted words and stall at random.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) digests.check_word(out_data_o);
    out_stall_i <= rst_ni && !steady && ($urandom_range(99) < 17);
  end

  task automatic send_word(logic [63:0] data, logic [3:0] cnt, logic last);
    in_word_t w;
    w.data_word = data;
    w.byte_count = cnt;
    w.last_word = last;
    if (!steady && $urandom_range(99) < 17) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    digests.note_word(w);
    words_sent++;
  endtask

  // Pattern: 0 random, 1 all zeros, 2 all ones.
  task automatic send_msg(int unsigned len, logic [3:0] last_cnt, int pattern);
    logic [63:0] d;
    for (int i = 0; i < len; i++) begin
      d = (pattern == 1) ? '0 : (pattern == 2) ? '1 : {$urandom, $urandom};
      if (i == len - 1) begin
        send_word(d, last_cnt, 1'b1);
      end else begin
        send_word(d, 4'($urandom_range(15)), 1'b0);
      end
    end
  endtask

  // Holds the sender back until every digest word has arrived, then lets the core settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (digests.pending() != 0);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [6:0] idx, logic [6:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    digests.set_reg(idx, val);
  endtask

  initial begin
    logic [6:0] dlens[6];
    logic [6:0] klens[6];
    int unsigned phase_start, len;
    dlens = '{7'd1, 7'd127, 7'd0, 7'd20, 7'd33, 7'd64};
    klens = '{7'd0, 7'd127, 7'd64, 7'd32, 7'd0, 7'd1};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: empty message, extreme data, oversized and partial counts,
    // and a full buffer closed by an empty last word.
    send_msg(1, 4'd0, 1);
    send_msg(1, 4'd8, 2);
    send_msg(1, 4'd15, 2);
    send_msg(1, 4'd3, 2);
    send_msg(17, 4'd0, 0);
    send_word('1, 4'd0, 1'b1);
    drain();

    // Random messages under several length settings, keyed where a key length is set.
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_DLEN, dlens[p]);
      write_reg(REG_KLEN, klens[p]);
      steady = (p == 2);
      phase_start = words_sent;
      while (words_sent - phase_start < 30) begin
        if (klens[p] != 0) begin
          for (int k = 0; k < 16; k++) send_word({$urandom, $urandom}, 4'd8, 1'b0);
        end
        len = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 17);
        send_msg(len, 4'($urandom_range(15)), 0);
        if ($urandom_range(3) == 0) drain();
      end
      steady = 1'b0;
      drain();
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (digests.pending() != 0);
    repeat (100) @(posedge clk_i);
    if (digests.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

[blake2b_hash_engine_core.f]
hw/rtl/b2b_pkg.sv
hw/rtl/b2b_half_g.sv
hw/rtl/b2b_round_unit.sv
hw/rtl/blake2b_hash_engine_core.sv
hw/rtl/b2b_checker.sv
tb/sv/tb_top.sv
